[sv/dsp_pkg.sv]
// Shared types and constants of the dense shortest-path distance block.
// No dependencies; imported by dsp_alu, the top level and the testbench.
package dsp_pkg;

    localparam int MAX_NODES_DEF   = 16;
    localparam int WEIGHT_BITS_DEF = 10;
    localparam int MIN_NODES       = 2;

    localparam logic [15:0] DIST_MAX       = 16'hFFFF;
    localparam logic [4:0]  NODE_COUNT_RST = 5'd16;
    localparam logic [15:0] INF_THRESH_RST = 16'd1000;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INF_THRESH = 1'b1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SELECT,
        ST_RELAX,
        ST_OUT
    } t_state;

    typedef enum logic {
        ALU_MIN,
        ALU_RELAX
    } t_alu_op;

    typedef struct packed {
        t_alu_op op;
        logic    live;
    } t_alu_req;

endpackage

[sv/dsp_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing outside itself; used for weights and distances.
module dsp_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/dsp_alu.sv]
// Shared compare/add unit: minimum search and saturated relaxation.
// Depends on dsp_pkg.
module dsp_alu
    import dsp_pkg::*;
#(
    parameter int DW = 16,
    parameter int WB = 10
) (
    input  t_alu_req        i_req,
    input  logic [DW-1:0]   i_dist,
    input  logic [DW-1:0]   i_ref,
    input  logic [WB-1:0]   i_weight,
    output logic            o_take,
    output logic [DW-1:0]   o_value
);

    logic [DW:0]   sum;
    logic [DW-1:0] sat;

    always_comb begin
        sum = {1'b0, i_ref} + (DW+1)'(i_weight);
        sat = (sum > (DW+1)'(DIST_MAX)) ? DW'(DIST_MAX) : sum[DW-1:0];
        case (i_req.op)
            ALU_MIN: begin
                o_take  = i_req.live && (i_dist < i_ref);
                o_value = i_dist;
            end
            ALU_RELAX: begin
                o_take  = i_req.live && (i_dist > sat);
                o_value = sat;
            end
            default: begin
                o_take  = 1'b0;
                o_value = i_dist;
            end
        endcase
    end

endmodule

[sv/dense_shortest_path_distances.sv]
// Top level: sequencer for dense shortest-path distances over a weight RAM.
// Depends on dsp_pkg, dsp_ram and dsp_alu.
//
//  channel | direction | handshake                    | word
//  --------+-----------+------------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_ready      | cmd, row, col, weight, source
//  out     | output    | o_out_valid / i_out_ready    | target_node, distance, last
//  cfg     | input     | i_cfg_we                     | i_cfg_addr, i_cfg_data
//
// A weight write is stored when the word is accepted. A query loads the source row,
// then runs n-2 rounds (one pass through the distance RAM for the minimum, one
// for relaxation, both on the shared compare/add unit), then streams the n results;
// no new input word is taken until the last result has been issued.
// Synchronous active-low reset clears control state; RAMs hold no reset.
// A stalled output holds the result stream; the last word can wait while the
// next input word is accepted.
module dense_shortest_path_distances
    import dsp_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_cmd,
    input  logic [3:0]            i_row_node,
    input  logic [3:0]            i_col_node,
    input  logic [9:0]            i_edge_weight,
    input  logic [3:0]            i_source_node,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [3:0]            o_target_node,
    output logic [15:0]           o_distance,
    output logic                  o_last
);

    localparam int NB = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int AW = $clog2(MAX_NODES * MAX_NODES);
    localparam int DW = (WEIGHT_BITS > 16) ? WEIGHT_BITS : 16;

    t_state r_state, n_state;

    logic [4:0]           r_node_count;
    logic [15:0]          r_thresh;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_pend, n_pend;
    logic [NB-1:0]        r_pidx, n_pidx;
    logic [MAX_NODES-1:0] r_mask, n_mask;
    logic [DW-1:0]        r_min, n_min;
    logic [NB-1:0]        r_best, n_best;
    logic [DW-1:0]        r_bdist, n_bdist;
    logic [CW-1:0]        r_round, n_round;
    logic [CW-1:0]        r_n, n_n;
    logic [3:0]           r_src, n_src;
    logic                 r_src_ok, n_src_ok;

    logic                 r_ovalid;
    logic [3:0]           r_otarget;
    logic [15:0]          r_odist;
    logic                 r_olast;

    logic                   w_we, w_re;
    logic [AW-1:0]          w_waddr, w_raddr;
    logic [WEIGHT_BITS-1:0] w_wdata, w_rdata;
    logic                   d_we, d_re;
    logic [NB-1:0]          d_waddr, d_raddr;
    logic [DW-1:0]          d_wdata, d_rdata;

    t_alu_req      alu_req;
    logic          alu_take;
    logic [DW-1:0] alu_value;

    logic          in_acc, out_free, issue, out_issue, scan_done, out_done, o_load;
    logic [CW-1:0] n_clamp;
    logic [NB-1:0] rd_row, sel_best;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_ovalid || i_out_ready;
    assign issue    = (r_idx < r_n);
    assign out_issue = issue && (!r_pend || out_free);
    assign scan_done = r_pend && !issue;
    assign out_done  = !issue && (!r_pend || out_free);
    assign sel_best  = alu_take ? r_pidx : r_best;

    always_comb begin
        int nc;
        nc = 32'(r_node_count);
        if (nc < MIN_NODES) begin
            nc = MIN_NODES;
        end
        if (nc > MAX_NODES) begin
            nc = MAX_NODES;
        end
        n_clamp = CW'(nc);
    end

    dsp_ram #(.DEPTH(MAX_NODES * MAX_NODES), .WIDTH(WEIGHT_BITS)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    dsp_ram #(.DEPTH(MAX_NODES), .WIDTH(DW)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_re    (d_re),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    dsp_alu #(.DW(DW), .WB(WEIGHT_BITS)) u_alu (
        .i_req    (alu_req),
        .i_dist   (d_rdata),
        .i_ref    ((r_state == ST_RELAX) ? r_bdist : r_min),
        .i_weight (w_rdata),
        .o_take   (alu_take),
        .o_value  (alu_value)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_cmd == CMD_QUERY)) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                if (scan_done) begin
                    n_state = (r_round != '0) ? ST_SELECT : ST_OUT;
                end
            end
            ST_SELECT: begin
                if (scan_done) begin
                    n_state = ST_RELAX;
                end
            end
            ST_RELAX: begin
                if (scan_done) begin
                    n_state = (r_round == CW'(1)) ? ST_OUT : ST_SELECT;
                end
            end
            ST_OUT: begin
                if (out_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_pidx   = r_pidx;
        n_mask   = r_mask;
        n_min    = r_min;
        n_best   = r_best;
        n_bdist  = r_bdist;
        n_round  = r_round;
        n_n      = r_n;
        n_src    = r_src;
        n_src_ok = r_src_ok;
        o_load   = 1'b0;

        rd_row  = (r_state == ST_INIT) ? NB'(r_src) : r_best;
        w_raddr = AW'(AW'(rd_row) * AW'(MAX_NODES) + AW'(r_idx[NB-1:0]));
        w_re    = 1'b0;
        w_we    = 1'b0;
        w_waddr = AW'(AW'(i_row_node) * AW'(MAX_NODES) + AW'(i_col_node));
        w_wdata = WEIGHT_BITS'(i_edge_weight);
        d_re    = 1'b0;
        d_raddr = r_idx[NB-1:0];
        d_we    = 1'b0;
        d_waddr = r_pidx;
        d_wdata = alu_value;
        alu_req = '{op: ALU_MIN, live: 1'b0};

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_cmd == CMD_WRITE) begin
                        w_we = (32'(i_row_node) < MAX_NODES) && (32'(i_col_node) < MAX_NODES);
                    end else begin
                        n_n      = n_clamp;
                        n_round  = CW'(n_clamp - CW'(MIN_NODES));
                        n_src    = i_source_node;
                        n_src_ok = (32'(i_source_node) < MAX_NODES);
                        n_mask   = '0;
                        n_idx    = '0;
                        n_pend   = 1'b0;
                    end
                end
            end
            ST_INIT: begin
                w_re   = issue;
                n_pend = issue;
                n_pidx = r_idx[NB-1:0];
                n_idx  = issue ? CW'(r_idx + CW'(1)) : r_idx;
                if (r_pend) begin
                    d_we    = 1'b1;
                    d_wdata = r_src_ok ? DW'(w_rdata) : '0;
                    n_mask[r_pidx] = (32'(r_pidx) != 32'(r_src));
                end
                if (scan_done) begin
                    n_idx  = '0;
                    n_pend = 1'b0;
                    n_min  = DW'(r_thresh);
                    n_best = '0;
                end
            end
            ST_SELECT: begin
                d_re    = issue;
                n_pend  = issue;
                n_pidx  = r_idx[NB-1:0];
                n_idx   = issue ? CW'(r_idx + CW'(1)) : r_idx;
                alu_req = '{op: ALU_MIN, live: r_pend && r_mask[r_pidx]};
                if (r_pend) begin
                    // bdist tracks the distance of the current pick, node 0 included
                    if (alu_take) begin
                        n_min   = d_rdata;
                        n_best  = r_pidx;
                        n_bdist = d_rdata;
                    end else if (r_pidx == '0) begin
                        n_bdist = d_rdata;
                    end
                end
                if (scan_done) begin
                    n_idx  = '0;
                    n_pend = 1'b0;
                    n_mask[sel_best] = 1'b0;
                end
            end
            ST_RELAX: begin
                d_re    = issue;
                w_re    = issue;
                n_pend  = issue;
                n_pidx  = r_idx[NB-1:0];
                n_idx   = issue ? CW'(r_idx + CW'(1)) : r_idx;
                alu_req = '{op: ALU_RELAX, live: r_pend && r_mask[r_pidx]};
                d_we    = alu_take;
                if (scan_done) begin
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_round = CW'(r_round - CW'(1));
                    n_min   = DW'(r_thresh);
                    n_best  = '0;
                end
            end
            ST_OUT: begin
                d_re   = out_issue;
                n_pidx = out_issue ? r_idx[NB-1:0] : r_pidx;
                n_idx  = out_issue ? CW'(r_idx + CW'(1)) : r_idx;
                o_load = r_pend && out_free;
                n_pend = out_issue || (r_pend && !out_free);
                if (out_done) begin
                    n_idx  = '0;
                    n_pend = 1'b0;
                end
            end
            default: begin
                n_idx  = '0;
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_mask       <= '0;
            r_ovalid     <= 1'b0;
            r_node_count <= NODE_COUNT_RST;
            r_thresh     <= INF_THRESH_RST;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_mask  <= n_mask;
            if (o_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_NODE_COUNT: r_node_count <= i_cfg_data[4:0];
                    CFG_INF_THRESH: r_thresh     <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx   <= n_pidx;
        r_min    <= n_min;
        r_best   <= n_best;
        r_bdist  <= n_bdist;
        r_round  <= n_round;
        r_n      <= n_n;
        r_src    <= n_src;
        r_src_ok <= n_src_ok;
        if (o_load) begin
            r_otarget <= 4'(r_pidx);
            r_odist   <= d_rdata[15:0];
            r_olast   <= (32'(r_pidx) + 1 == 32'(r_n));
        end
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_ovalid;
    assign o_target_node = r_otarget;
    assign o_distance    = r_odist;
    assign o_last        = r_olast;

endmodule

[verif/testbench.sv]
// Self-checking testbench for dense_shortest_path_distances: fills the weight store,
// runs distance queries under several node counts and thresholds, checks every distance
// word against an in-bench shortest-path predictor or directed-row values; uses dsp_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dsp_pkg::*;

    typedef struct packed {
        logic [3:0]  target;
        logic [15:0] distance;
        logic        is_last;
    } t_dist_word;

    typedef enum logic {ROW_WORD, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic                 cmd;
        logic [3:0]           row;
        logic [3:0]           col;
        logic [9:0]           wt;
        logic [3:0]           src;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic [15:0]          reg_val;
        bit                   typed;
        logic [15:0]          d0;
        logic [15:0]          d1;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = CFG_NODE_COUNT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_cmd = CMD_WRITE;
    logic [3:0]            i_row_node = '0;
    logic [3:0]            i_col_node = '0;
    logic [9:0]            i_edge_weight = '0;
    logic [3:0]            i_source_node = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [3:0]            o_target_node;
    logic [15:0]           o_distance;
    logic                  o_last;

    // predictor state
    logic [9:0]  weight_mem [MAX_NODES_DEF][MAX_NODES_DEF];
    bit          weight_set [MAX_NODES_DEF][MAX_NODES_DEF];
    logic [4:0]  node_cnt = NODE_COUNT_RST;
    logic [15:0] thr_reg = INF_THRESH_RST;

    t_dist_word pending_dists [$];
    t_dist_word want;
    int         err_count = 0;
    int         in_calm = 0;
    int         out_calm = 0;
    int         stall_left = 0;
    int         out_gap;

    dense_shortest_path_distances u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_row_node    (i_row_node),
        .i_col_node    (i_col_node),
        .i_edge_weight (i_edge_weight),
        .i_source_node (i_source_node),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_target_node (o_target_node),
        .o_distance    (o_distance),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [9:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 10'd0;
        if (r < 20) return 10'h3FF;
        if (r < 60) return 10'($urandom_range(1, 60));
        return 10'($urandom);
    endfunction

    function automatic int eff_nodes();
        int n;
        n = node_cnt;
        if (n < MIN_NODES) n = MIN_NODES;
        if (n > MAX_NODES_DEF) n = MAX_NODES_DEF;
        return n;
    endfunction

    // Find an unwritten weight that a query at n nodes may read: the core
    // n x n block, or the first n columns of one source row.
    function automatic bit has_gap(input int n, input int only_row,
                                   output logic [3:0] r, output logic [3:0] c);
        r = '0;
        c = '0;
        for (int i = 0; i < MAX_NODES_DEF; i++) begin
            if (only_row < 0 ? i < n : i == only_row) begin
                for (int j = 0; j < n; j++) begin
                    if (!weight_set[i][j]) begin
                        r = 4'(i);
                        c = 4'(j);
                        return 1'b1;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic void predict_distances(input logic [3:0] src);
        int          n;
        int          best;
        logic [15:0] row_d [MAX_NODES_DEF];
        logic [MAX_NODES_DEF-1:0] open_set;
        logic [15:0] lo;
        logic [16:0] sum;
        n = eff_nodes();
        open_set = '0;
        for (int i = 0; i < n; i++) begin
            row_d[i] = 16'(weight_mem[src][i]);
            if (i != src) open_set[i] = 1'b1;
        end
        for (int rd = 0; rd + 2 < n; rd++) begin
            // nothing below threshold: node 0 is taken, visited or not
            best = 0;
            lo = thr_reg;
            for (int i = 0; i < n; i++) begin
                if (open_set[i] && row_d[i] < lo) begin
                    lo = row_d[i];
                    best = i;
                end
            end
            open_set[best] = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (open_set[i]) begin
                    sum = {1'b0, row_d[best]} + 17'(weight_mem[best][i]);
                    if (sum > 17'(DIST_MAX)) sum = 17'(DIST_MAX);
                    if ({1'b0, row_d[i]} > sum) row_d[i] = sum[15:0];
                end
            end
        end
        for (int i = 0; i < n; i++)
            pending_dists.push_back('{target: 4'(i), distance: row_d[i],
                                      is_last: (i == n - 1)});
    endfunction

    task automatic send_word(input logic cmd, input logic [3:0] row, input logic [3:0] col,
                             input logic [9:0] wt, input logic [3:0] src, input bit typed,
                             input logic [15:0] d0, input logic [15:0] d1);
        int gap;
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_row_node    <= row;
        i_col_node    <= col;
        i_edge_weight <= wt;
        i_source_node <= src;
        do @(posedge i_clk); while (!o_in_ready);
        if (cmd == CMD_WRITE) begin
            weight_mem[row][col] = wt;
            weight_set[row][col] = 1'b1;
        end else if (typed) begin
            pending_dists.push_back('{target: 4'd0, distance: d0, is_last: 1'b0});
            pending_dists.push_back('{target: 4'd1, distance: d1, is_last: 1'b1});
        end else begin
            predict_distances(src);
        end
        gap = idle_len(in_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain the block before touching a register; a trailing write may still be in flight.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [15:0] val);
        i_in_valid <= 1'b0;
        while (pending_dists.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= sel;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (sel == CFG_NODE_COUNT) node_cnt = val[4:0];
        else thr_reg = val;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            out_gap = idle_len(out_calm);
            if (out_gap > 0) begin
                i_out_ready <= 1'b0;
                stall_left = out_gap - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_dists.size() == 0) begin
                $error("unexpected distance word: node %0d distance %0d",
                       o_target_node, o_distance);
                err_count++;
            end else begin
                want = pending_dists.pop_front();
                if (o_target_node !== want.target) begin
                    $error("target_node: expected %0d, got %0d", want.target, o_target_node);
                    err_count++;
                end
                if (o_distance !== want.distance) begin
                    $error("distance: expected %0d, got %0d", want.distance, o_distance);
                    err_count++;
                end
                if (o_last !== want.is_last) begin
                    $error("last: expected %0d, got %0d", want.is_last, o_last);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_dir_row    dir_rows [25];
        int          phase_nc [8];
        int          phase_thr [8];
        int          nc;
        int          th;
        int          n;
        int          r;
        int          queries;
        logic [3:0]  src;
        logic [3:0]  fr;
        logic [3:0]  fc;

        // two nodes first: no rounds, so the answer is the source row itself
        dir_rows = '{
            '{ROW_REG,  CMD_WRITE, 0,  0,  0,      0,  CFG_NODE_COUNT, 2,     0, 0, 0},
            '{ROW_WORD, CMD_WRITE, 0,  0,  0,      0,  CFG_NODE_COUNT, 0,     0, 0, 0},
            '{ROW_WORD, CMD_WRITE, 0,  1,  1023,   0,  CFG_NODE_COUNT, 0,     0, 0, 0},
            '{ROW_WORD, CMD_WRITE, 1,  0,  1023,   0,  CFG_NODE_COUNT, 0,     0, 0, 0},
            '{ROW_WORD, CMD_WRITE, 1,  1,  0,      0,  CFG_NODE_COUNT, 0,     0, 0, 0},
            '{ROW_WORD, CMD_WRITE, 15, 0,  5,      0,  CFG_NODE_COUNT, 0,     0, 0, 0},
            '{ROW_WORD, CMD_WRITE, 15, 1,  1023,   0,  CFG_NODE_COUNT, 0,     0, 0, 0},
            '{ROW_WORD, CMD_WRITE, 3,  15, 10'h2AA, 0, CFG_NODE_COUNT, 0,     0, 0, 0},
            '{ROW_WORD, CMD_WRITE, 12, 10, 10'h155, 0, CFG_NODE_COUNT, 0,     0, 0, 0},
            '{ROW_WORD, CMD_QUERY, 0,  0,  0,      0,  CFG_NODE_COUNT, 0,     1, 0, 1023},
            '{ROW_WORD, CMD_QUERY, 0,  0,  0,      1,  CFG_NODE_COUNT, 0,     1, 1023, 0},
            // source beyond the node count still reads its own row
            '{ROW_WORD, CMD_QUERY, 0,  0,  0,      15, CFG_NODE_COUNT, 0,     1, 5, 1023},
            // node count of zero clamps to two
            '{ROW_REG,  CMD_WRITE, 0,  0,  0,      0,  CFG_NODE_COUNT, 0,     0, 0, 0},
            '{ROW_WORD, CMD_QUERY, 0,  0,  0,      0,  CFG_NODE_COUNT, 0,     1, 0, 1023},
            '{ROW_REG,  CMD_WRITE, 0,  0,  0,      0,  CFG_NODE_COUNT, 3,     0, 0, 0},
            '{ROW_WORD, CMD_WRITE, 0,  2,  1000,   0,  CFG_NODE_COUNT, 0,     0, 0, 0},
            '{ROW_WORD, CMD_WRITE, 1,  2,  1,      0,  CFG_NODE_COUNT, 0,     0, 0, 0},
            '{ROW_WORD, CMD_WRITE, 2,  0,  7,      0,  CFG_NODE_COUNT, 0,     0, 0, 0},
            '{ROW_WORD, CMD_WRITE, 2,  1,  1023,   0,  CFG_NODE_COUNT, 0,     0, 0, 0},
            '{ROW_WORD, CMD_WRITE, 2,  2,  0,      0,  CFG_NODE_COUNT, 0,     0, 0, 0},
            // reset threshold: nothing qualifies, node 0 is taken again
            '{ROW_WORD, CMD_QUERY, 0,  0,  0,      0,  CFG_NODE_COUNT, 0,     0, 0, 0},
            '{ROW_REG,  CMD_WRITE, 0,  0,  0,      0,  CFG_INF_THRESH, 0,     0, 0, 0},
            '{ROW_WORD, CMD_QUERY, 0,  0,  0,      2,  CFG_NODE_COUNT, 0,     0, 0, 0},
            '{ROW_REG,  CMD_WRITE, 0,  0,  0,      0,  CFG_INF_THRESH, 65535, 0, 0, 0},
            '{ROW_WORD, CMD_QUERY, 0,  0,  0,      0,  CFG_NODE_COUNT, 0,     0, 0, 0}
        };
        phase_nc  = '{4, 16, 31, 1, 8, 16, 0, 0};
        phase_thr = '{1000, 500, 1000, 300, 1, 65535, 0, 0};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_REG)
                write_reg(dir_rows[k].reg_sel, dir_rows[k].reg_val);
            else
                send_word(dir_rows[k].cmd, dir_rows[k].row, dir_rows[k].col, dir_rows[k].wt,
                          dir_rows[k].src, dir_rows[k].typed, dir_rows[k].d0, dir_rows[k].d1);
        end

        for (int p = 0; p < 8; p++) begin
            nc = phase_nc[p];
            th = phase_thr[p];
            if (p >= 6) begin
                nc = $urandom_range(2, 16);
                th = $urandom_range(1, 65535);
            end
            write_reg(CFG_NODE_COUNT, 16'(nc));
            write_reg(CFG_INF_THRESH, 16'(th));
            n = eff_nodes();
            queries = 0;
            while (queries < 5) begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    send_word(CMD_WRITE, 4'($urandom), 4'($urandom), pick_weight(),
                              4'($urandom), 1'b0, 16'd0, 16'd0);
                end else if (has_gap(n, -1, fr, fc)) begin
                    // fill the core block before any query may read it
                    send_word(CMD_WRITE, fr, fc, pick_weight(), 4'($urandom),
                              1'b0, 16'd0, 16'd0);
                end else if (r < 60) begin
                    src = 4'($urandom);
                    if (has_gap(n, src, fr, fc) && r < 36) begin
                        send_word(CMD_WRITE, fr, fc, pick_weight(), src, 1'b0, 16'd0, 16'd0);
                    end else begin
                        if (has_gap(n, src, fr, fc)) src = 4'($urandom_range(0, n - 1));
                        send_word(CMD_QUERY, 4'($urandom), 4'($urandom), 10'($urandom), src,
                                  1'b0, 16'd0, 16'd0);
                        queries++;
                    end
                end else begin
                    send_word(CMD_WRITE, 4'($urandom), 4'($urandom_range(0, n - 1)),
                              pick_weight(), 4'($urandom), 1'b0, 16'd0, 16'd0);
                end
            end
        end

        // drop valid so the last word is not taken twice
        i_in_valid <= 1'b0;
        while (pending_dists.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (err_count == 0 && pending_dists.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
sv/dsp_pkg.sv
sv/dsp_ram.sv
sv/dsp_alu.sv
sv/dense_shortest_path_distances.sv
verif/testbench.sv
